// ----- hw/rtl/scdf_pkg.sv -----
// scdf_pkg: shared types and constants of the serial command deframer
// holds the parse phase enum, register indexes, reset values and the result word
// no dependencies
`timescale 1ns / 1ps

package scdf_pkg;

   // parse phases of the deframer
   typedef enum logic [1:0] {
      PH_HDR1 = 2'd0,
      PH_HDR2 = 2'd1,
      PH_LEN  = 2'd2,
      PH_DATA = 2'd3
   } scdf_phase_type;

   // default command buffer depth in bytes
   localparam int unsigned BufferDepthDefault = 64;

   // control register indexes
   localparam int unsigned CsrIndexWidth = 2;
   localparam logic [CsrIndexWidth-1:0] CSR_FIRST_HEADER  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SECOND_HEADER = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_PASSTHROUGH   = 2'd2;

   // control register reset values
   localparam logic [7:0] FirstHeaderReset  = 8'd84;
   localparam logic [7:0] SecondHeaderReset = 8'd254;
   localparam logic [7:0] PassthroughReset  = 8'd17;

   // control register contents
   typedef struct packed {
      logic [7:0] first_header;
      logic [7:0] second_header;
      logic [7:0] passthrough_code;
   } scdf_cfg_type;

   // one result word
   typedef struct packed {
      logic       store_strobe;
      logic       store_buffer;
      logic [7:0] store_index;
      logic [7:0] store_data;
      logic       packet_end;
      logic       checksum_good;
      logic       command_ready;
      logic       ready_buffer;
   } scdf_result_type;

endpackage

// ----- hw/rtl/scdf_if.sv -----
// scdf_if: valid/ready channels of the deframer
// request channel carries received bytes, response channel carries result words
// no dependencies
`timescale 1ns / 1ps

// received byte channel
interface scdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// result channel
interface scdf_rsp_if;
   logic       valid;
   logic       ready;
   logic       store_strobe;
   logic       store_buffer;
   logic [7:0] store_index;
   logic [7:0] store_data;
   logic       packet_end;
   logic       checksum_good;
   logic       command_ready;
   logic       ready_buffer;

   modport source (
      output valid, output store_strobe, output store_buffer, output store_index,
      output store_data, output packet_end, output checksum_good,
      output command_ready, output ready_buffer, input ready
   );
   modport sink (
      input valid, input store_strobe, input store_buffer, input store_index,
      input store_data, input packet_end, input checksum_good,
      input command_ready, input ready_buffer, output ready
   );
endinterface

// ----- hw/rtl/serial_command_deframer_unit.sv -----
// serial_command_deframer_unit: top level of the serial command deframer
// an accepted byte's result word is registered and appears on rsp_ch in the next cycle
// throughput: one byte per cycle while rsp_ch is not stalled, set by the single result register stage
// reset: synchronous, clears parse state, buffer select and result valid,
//   and loads the header and passthrough registers with their defaults
`timescale 1ns / 1ps

module serial_command_deframer_unit
   import scdf_pkg::*;
#(
   parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   scdf_req_if.sink                 req_ch,
   scdf_rsp_if.source               rsp_ch,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [7:0]               csr_wdata
);

   scdf_cfg_type    cfg;
   scdf_result_type result;
   logic            has_room;
   logic            take;

   // accept a word whenever the result register can take its result
   assign req_ch.ready = has_room;
   assign take         = req_ch.valid && has_room;

   // control registers
   scdf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // parse state and result logic
   scdf_parser #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .rx_byte (req_ch.rx_byte),
      .cfg     (cfg),
      .result  (result)
   );

   // result register
   scdf_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (take),
      .result   (result),
      .has_room (has_room),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ----- hw/rtl/scdf_csr.sv -----
// scdf_csr: control registers of the deframer (header bytes, passthrough code)
// depends on scdf_pkg
`timescale 1ns / 1ps

module scdf_csr
   import scdf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [7:0]               csr_wdata,
   output scdf_cfg_type             cfg
);

   scdf_cfg_type cfg_ff;
   scdf_cfg_type cfg_in;

   // register write decode, unknown indexes ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FIRST_HEADER:  cfg_in.first_header     = csr_wdata;
            CSR_SECOND_HEADER: cfg_in.second_header    = csr_wdata;
            CSR_PASSTHROUGH:   cfg_in.passthrough_code = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_header     <= FirstHeaderReset;
         cfg_ff.second_header    <= SecondHeaderReset;
         cfg_ff.passthrough_code <= PassthroughReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/scdf_parser.sv -----
// scdf_parser: packet parse state and per-word result logic
// hunts headers, counts payload, sums checksum, flips ping-pong buffers
// depends on scdf_pkg
`timescale 1ns / 1ps

module scdf_parser
   import scdf_pkg::*;
#(
   parameter int unsigned BUFFER_DEPTH = BufferDepthDefault
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  logic [7:0]      rx_byte,
   input  scdf_cfg_type    cfg,
   output scdf_result_type result
);

   localparam logic [7:0] DepthLimit = 8'(BUFFER_DEPTH);

   scdf_phase_type phase_ff, phase_in;
   logic [7:0]     length_ff, length_in;
   logic [7:0]     count_ff, count_in;
   logic [7:0]     sum_ff, sum_in;
   logic           pass_ff, pass_in;
   logic           fill_ff, fill_in;

   logic           data_last;
   logic           pass_now;

   // checksum byte reached when count + 1 covers the length
   assign data_last = ({1'b0, count_ff} + 9'd1) >= {1'b0, length_ff};
   // passthrough marker only at payload position zero
   assign pass_now  = pass_ff || (count_ff == 8'd0 && rx_byte == cfg.passthrough_code);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_HDR1: if (rx_byte == cfg.first_header) phase_in = PH_HDR2;
         PH_HDR2: phase_in = (rx_byte == cfg.second_header) ? PH_LEN : PH_HDR1;
         PH_LEN:  phase_in = (rx_byte == 8'd0) ? PH_HDR1 : PH_DATA;
         PH_DATA: if (data_last) phase_in = PH_HDR1;
         default: phase_in = PH_HDR1;
      endcase
   end

   // datapath updates and result word
   always_comb begin
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      pass_in   = pass_ff;
      fill_in   = fill_ff;
      result    = '0;
      unique case (phase_ff)
         PH_LEN: begin
            if (rx_byte != 8'd0) begin
               length_in = rx_byte;
               count_in  = 8'd0;
               sum_in    = 8'd0;
               pass_in   = 1'b0;
            end
         end
         PH_DATA: begin
            if (data_last) begin
               result.packet_end    = 1'b1;
               result.checksum_good = (sum_ff == rx_byte);
               result.command_ready = (sum_ff == rx_byte) && !pass_ff;
               result.ready_buffer  = (sum_ff == rx_byte) && !pass_ff && fill_ff;
               fill_in = !fill_ff;
               pass_in = 1'b0;
            end else begin
               pass_in = pass_now;
               if (!pass_now && count_ff < DepthLimit) begin
                  result.store_strobe = 1'b1;
                  result.store_buffer = fill_ff;
                  result.store_index  = count_ff;
                  result.store_data   = rx_byte;
               end
               sum_in   = sum_ff + rx_byte;
               count_in = count_ff + 8'd1;
            end
         end
         default: begin
            pass_in = pass_ff;
         end
      endcase
   end

   // parse state, updated on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR1;
         length_ff <= 8'd0;
         count_ff  <= 8'd0;
         sum_ff    <= 8'd0;
         pass_ff   <= 1'b0;
         fill_ff   <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         pass_ff   <= pass_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- hw/rtl/scdf_rsp_reg.sv -----
// scdf_rsp_reg: result register in front of the response channel
// takes a new word whenever empty or being drained in the same cycle
// depends on scdf_pkg and scdf_if
`timescale 1ns / 1ps

module scdf_rsp_reg
   import scdf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  scdf_result_type    result,
   output logic               has_room,
   scdf_rsp_if.source         rsp_ch
);

   logic            valid_ff, valid_in;
   scdf_result_type data_ff;

   // room when empty or the held word leaves this cycle
   assign has_room = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   // drive the channel
   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.store_strobe  = data_ff.store_strobe;
   assign rsp_ch.store_buffer  = data_ff.store_buffer;
   assign rsp_ch.store_index   = data_ff.store_index;
   assign rsp_ch.store_data    = data_ff.store_data;
   assign rsp_ch.packet_end    = data_ff.packet_end;
   assign rsp_ch.checksum_good = data_ff.checksum_good;
   assign rsp_ch.command_ready = data_ff.command_ready;
   assign rsp_ch.ready_buffer  = data_ff.ready_buffer;

endmodule
